@@ rtl/core/block_average_pixelate_2x2_top_defines.svh @@
// Assertion macros shared by the 2x2 pixelate checker.
`ifndef BLOCK_AVERAGE_PIXELATE_2X2_TOP_DEFINES_SVH
`define BLOCK_AVERAGE_PIXELATE_2X2_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bap_pkg.sv @@
// Package: constants, job type and geometry helpers for the 2x2 pixelate block.
`default_nettype none
package bap_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int SUM2_W = PIX_W + 1;   // pair sum
  localparam int SUM4_W = PIX_W + 2;   // block sum
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int WID_W  = 11;          // frame_width register
  localparam int HGT_W  = 13;          // frame_height register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int PAIR_AW    = COL_W - 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // One queued job: a pass-through pixel or a finished 2x2 block.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             blk;
  } job_t;

  // Zero reads as one, oversize saturates.
  function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
    logic [WID_W-1:0] r;
    r = v;
    if (r == '0) r = WID_W'(1);
    if (r > WID_W'(MAX_WIDTH)) r = WID_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
    logic [HGT_W-1:0] r;
    r = v;
    if (r == '0) r = HGT_W'(1);
    if (r > HGT_W'(MAX_HEIGHT)) r = HGT_W'(MAX_HEIGHT);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/block_average_pixelate_2x2_top.sv @@
// Top level of the 2x2 block-average pixelate block.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall  in_pixel[7:0]
//   out_     out        out_valid/out_stall out_row[11:0] out_col[9:0] out_value[7:0]
//                                           out_last_of_run
//   cfg_     in         cfg_valid/cfg_ready cfg_index[1:0] cfg_data[12:0]
//
// One pixel is taken per clock while in_stall is low. A finished 2x2 block
// leaves the back end as four results; the 4-entry job queue between the
// ends absorbs the burst, so odd rows stall input once it fills.
// A pixel reaches its first result through the line buffer read, queue,
// job register and output register.
// Reset clears counters, geometry (1024 x 1024) and the pipeline; the line
// buffer is not cleared, an entry is always written on the even row above
// before it is read. cfg_ready is always high; a geometry write restarts
// the frame.
`default_nettype none
module block_average_pixelate_2x2_top import bap_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_pixel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ROW_W-1:0]           out_row,
  output logic [COL_W-1:0]           out_col,
  output logic [PIX_W-1:0]           out_value,
  output logic                       out_last_of_run,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic push, q_full, q_empty, pop;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  // front: counters, classification, line buffer, block sum
  bap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  bap_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // back: one result per clock while out_stall is low, output register holds under out_stall
  bap_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

@@ rtl/core/bap_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bap_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bap_front.sv @@
// Front end: geometry registers, raster counters, line buffer and job build.
`default_nettype none
module bap_front import bap_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_pixel,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       push,
  output job_t                       push_job,
  input  wire logic                  q_full
);

  logic [WID_W-1:0]  width_r,  width_nxt;
  logic [HGT_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0]  col_r,    col_nxt;
  logic [ROW_W-1:0]  row_r,    row_nxt;
  logic [PIX_W-1:0]  held_r,   held_nxt;

  logic              s1_v_r,   s1_v_nxt;
  logic              s1_blk_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [SUM2_W-1:0] s1_part_r;

  logic [WID_W-1:0]  col_inc;
  logic [HGT_W-1:0]  row_inc;
  logic              col_end, row_end, tail;
  logic              accept, is_blk, is_pair, is_hold, emits;
  logic [SUM2_W-1:0] pair_sum;
  logic [SUM2_W-1:0] above;
  logic [SUM4_W-1:0] blk_sum;

  assign col_inc = {1'b0, col_r} + WID_W'(1);
  assign row_inc = {1'b0, row_r} + HGT_W'(1);
  assign col_end = (col_inc >= width_r);
  assign row_end = (row_inc >= height_r);
  // trailing odd column or odd row passes through
  assign tail = (width_r[0] && (col_inc == width_r)) ||
                (height_r[0] && (row_inc == height_r));

  assign is_blk  = !tail &&  col_r[0] &&  row_r[0];
  assign is_pair = !tail &&  col_r[0] && !row_r[0];
  assign is_hold = !tail && !col_r[0];
  assign emits   = tail || is_blk;

  assign in_stall = s1_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_v_r && !q_full;

  assign pair_sum = {1'b0, held_r} + {1'b0, in_pixel};

  bap_ram #(
    .WIDTH (SUM2_W),
    .DEPTH (PAIR_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && is_pair),
    .waddr (col_r[COL_W-1:1]),
    .wdata (pair_sum),
    .re    (accept && is_blk),
    .raddr (col_r[COL_W-1:1]),
    .rdata (above)
  );

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    held_nxt   = held_r;
    if (accept) begin
      if (is_hold) held_nxt = in_pixel;
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
    if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_nxt = clamp_width(cfg_data[WID_W-1:0]);
      end else begin
        height_nxt = clamp_height(cfg_data[HGT_W-1:0]);
      end
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_comb begin
    if (accept && emits) s1_v_nxt = 1'b1;
    else if (push)       s1_v_nxt = 1'b0;
    else                 s1_v_nxt = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(1024);
      height_r <= HGT_W'(1024);
      col_r    <= '0;
      row_r    <= '0;
      held_r   <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      held_r   <= held_nxt;
      s1_v_r   <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emits) begin
      s1_blk_r  <= is_blk;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_part_r <= is_blk ? pair_sum : {1'b0, in_pixel};
    end
  end

  // line buffer word arrives here in the cycle after the read
  assign blk_sum = {1'b0, above} + {1'b0, s1_part_r};

  always_comb begin
    push_job.row   = s1_row_r;
    push_job.col   = s1_col_r;
    push_job.blk   = s1_blk_r;
    push_job.value = s1_blk_r ? blk_sum[SUM4_W-1:2] : s1_part_r[PIX_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/bap_queue.sv @@
// Short job queue between front and back ends.
`default_nettype none
module bap_queue import bap_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  job_t              slot [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r,  cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bap_back.sv @@
// Back end: expands jobs into one or four results behind an output register.
`default_nettype none
module bap_back import bap_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire job_t              q_job,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ROW_W-1:0]       out_row,
  output logic [COL_W-1:0]       out_col,
  output logic [PIX_W-1:0]       out_value,
  output logic                   out_last_of_run
);

  job_t             job_r;
  logic             job_v_r,  job_v_nxt;
  logic [1:0]       beat_r,   beat_nxt;
  logic             ov_r,     ov_nxt;
  logic [ROW_W-1:0] orow_r;
  logic [COL_W-1:0] ocol_r;
  logic [PIX_W-1:0] oval_r;
  logic             olast_r;

  logic             load, done;
  logic [ROW_W-1:0] b_row;
  logic [COL_W-1:0] b_col;
  logic             b_last;

  assign load = job_v_r && (!ov_r || !out_stall);
  assign done = load && (!job_r.blk || beat_r == 2'd3);
  assign pop  = !q_empty && (!job_v_r || done);

  // beat order: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    b_row  = job_r.row;
    b_col  = job_r.col;
    b_last = 1'b1;
    if (job_r.blk) begin
      if (!beat_r[1]) b_row = job_r.row - ROW_W'(1);
      if (!beat_r[0]) b_col = job_r.col - COL_W'(1);
      b_last = (beat_r == 2'd3);
    end
  end

  always_comb begin
    job_v_nxt = job_v_r;
    if (pop)       job_v_nxt = 1'b1;
    else if (done) job_v_nxt = 1'b0;
    beat_nxt = beat_r;
    if (load) beat_nxt = done ? 2'd0 : beat_r + 2'd1;
    if (load)           ov_nxt = 1'b1;
    else if (out_stall) ov_nxt = ov_r;
    else                ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      beat_r  <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      beat_r  <= beat_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
    if (load) begin
      orow_r  <= b_row;
      ocol_r  <= b_col;
      oval_r  <= job_r.value;
      olast_r <= b_last;
    end
  end

  assign out_valid       = ov_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_value       = oval_r;
  assign out_last_of_run = olast_r;

endmodule
`default_nettype wire

@@ rtl/core/bap_checker.sv @@
// Port-level checker for the 2x2 pixelate top, bound to it below.
`default_nettype none
`include "block_average_pixelate_2x2_top_defines.svh"
module bap_checker import bap_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [ROW_W-1:0]      out_row,
  input wire logic [COL_W-1:0]      out_col,
  input wire logic [PIX_W-1:0]      out_value,
  input wire logic                  out_last_of_run
);

  // stalled result holds
  `BAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_row) && $stable(out_col) && $stable(out_last_of_run), "stalled result changed")

  // a block burst runs without gaps and keeps one average
  `BAP_ASSERT_NEXT(a_burst, out_valid && !out_stall && !out_last_of_run, out_valid && (out_value == $past(out_value)), "block burst broken")

  // only the bottom-right corner of a block sits at odd row and odd column
  `BAP_ASSERT_NOW(a_corner, out_valid && !out_last_of_run, !(out_row[0] && out_col[0]), "non-last result at odd row and column")

endmodule

bind block_average_pixelate_2x2_top bap_checker u_bap_checker (.*);
`default_nettype wire
